[rtl/mrkl_pkg.sv]
// shared types, constants and helper functions for the merkle root engine
// no dependencies
package mrkl_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HASH,
        ST_WRB,
        ST_OUTR,
        ST_OUTW
    } state_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_PAD,
        PH_EMPTY
    } phase_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_PAIR,
        BLK_PAD_EMPTY
    } blk_sel_t;

    typedef struct packed {
        logic     wr_in;
        logic     wr_hash;
        logic     rd;
        logic     cap;
        logic [1:0] cap_slot;
        logic     out_load;
        logic     sha_start;
        logic     sha_init;
        blk_sel_t blk_sel;
    } cmd_t;

    typedef struct packed {
        logic sha_done;
    } stat_t;

    localparam logic [0:0] ACT_LEAF = 1'b0;
    localparam logic [0:0] ACT_END  = 1'b1;

    // padding block after a 128 byte message, and the block of the empty message
    localparam logic [511:0] PAD_PAIR  = {32'h8000_0000, 448'd0, 32'h0000_0400};
    localparam logic [511:0] PAD_EMPTY = {32'h8000_0000, 480'd0};

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // lowercase ascii hex of one 64-bit word, first nibble in the top byte
    function automatic logic [127:0] hex64(input logic [63:0] w);
        logic [3:0] n;
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            n = w[63 - 4 * i -: 4];
            r[127 - 8 * i -: 8] = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
        end
        hex64 = r;
    endfunction

endpackage

[rtl/merkle_root_sha256_hex.sv]
// top level of the merkle root engine
// depends on mrkl_pkg, mrkl_ctrl, mrkl_dp
//
// Leaf words are taken one per cycle and written straight into a single-port
// digest store of MAX_LEAVES*4 64-bit words. An end-of-set word stalls the
// input until the root's four words have been delivered. Each pair costs
// three SHA-256 compressions on one shared round unit, plus reading and
// hex-encoding each 64-character half and writing the parent back; n leaves
// need n-1 pairs (plus padding of odd levels). Each root word is read from
// the store into a result register and held there until the output is not
// stalled. The store has no reset pass.
module merkle_root_sha256_hex #(
    parameter int MAX_LEAVES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [63:0] leaf_word,
    input  logic [1:0]  leaf_word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] root_word,
    output logic [1:0]  root_word_index,
    output logic        last_word,
    output logic        truncated
);
    import mrkl_pkg::*;

    localparam int LW = $clog2(MAX_LEAVES);
    localparam int CW = $clog2(MAX_LEAVES + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [LW-1:0] leaf_addr;
    logic [1:0]    word_sel;

    mrkl_ctrl #(
        .MAX_LEAVES (MAX_LEAVES),
        .LW         (LW),
        .CW         (CW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .leaf_word_index (leaf_word_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .root_word_index (root_word_index),
        .last_word       (last_word),
        .truncated       (truncated),
        .cmd             (cmd),
        .stat            (stat),
        .leaf_addr       (leaf_addr),
        .word_sel        (word_sel)
    );

    mrkl_dp #(
        .MAX_LEAVES (MAX_LEAVES),
        .LW         (LW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .leaf_addr (leaf_addr),
        .word_sel  (word_sel),
        .leaf_word (leaf_word),
        .root_word (root_word)
    );

    // results only appear while the input side is held off
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while input open");

    // the final word is followed by the input opening again
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !in_stall && !out_valid)
        else $error("input not reopened after last word");

    // a new root always starts at word zero
    a_start_word0: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> root_word_index == 2'd0)
        else $error("root did not start at word zero");

endmodule

[rtl/mrkl_sha.sv]
// sha-256 compression unit, one round per clock
// depends on mrkl_pkg
module mrkl_sha (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           init,
    input  logic [511:0]   block,
    output logic [255:0]   hash,
    output logic           done
);
    import mrkl_pkg::*;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        run_reg;
    logic        done_reg;

    logic [31:0] v_next [8];
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        t1 = v_reg[7] + big_sig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + KROUND[rnd_reg] + w_reg[0];
        t2 = big_sig0(v_reg[0])
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
        w_new = sml_sig1(w_reg[14]) + w_reg[9] + sml_sig0(w_reg[1]) + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (init)
                begin
                    h_reg[i] <= H_INIT[255 - 32 * i -: 32];
                    v_reg[i] <= H_INIT[255 - 32 * i -: 32];
                end
                else
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            for (int j = 0; j < 16; j++)
                w_reg[j] <= block[511 - 32 * j -: 32];
        end
        else if (run_reg)
        begin
            for (int j = 0; j < 15; j++)
                w_reg[j] <= w_reg[j + 1];
            w_reg[15] <= w_new;
            if (rnd_reg == 6'd63)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_next[i];
            end
            else
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= v_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash[255 - 32 * i -: 32] = h_reg[i];
    end

    assign done = done_reg;

endmodule

[rtl/mrkl_dp.sv]
// datapath: digest store, hex block assembly, sha unit and result register
// depends on mrkl_pkg and mrkl_sha
module mrkl_dp #(
    parameter int MAX_LEAVES = 64,
    parameter int LW = $clog2(MAX_LEAVES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrkl_pkg::cmd_t       cmd,
    output mrkl_pkg::stat_t      stat,
    input  logic [LW-1:0]        leaf_addr,
    input  logic [1:0]           word_sel,
    input  logic [63:0]          leaf_word,
    output logic [63:0]          root_word
);
    import mrkl_pkg::*;

    localparam int DEPTH = MAX_LEAVES * 4;

    logic [63:0]  mem [DEPTH];
    logic [63:0]  rdata_reg;
    logic [511:0] blk_reg;
    logic [63:0]  root_reg;
    logic [LW+1:0] addr;
    logic [63:0]  wdata;
    logic [511:0] sha_blk;
    logic [255:0] hash;
    logic         sha_done;

    assign addr  = {leaf_addr, word_sel};
    assign wdata = cmd.wr_in ? leaf_word : hash[255 - 64 * word_sel -: 64];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_in || cmd.wr_hash)
            mem[addr] <= wdata;
        if (cmd.rd)
            rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            blk_reg[511 - 128 * cmd.cap_slot -: 128] <= hex64(rdata_reg);
        if (cmd.out_load)
            root_reg <= rdata_reg;
    end

    always_comb
    begin
        case (cmd.blk_sel)
            BLK_DATA:      sha_blk = blk_reg;
            BLK_PAD_PAIR:  sha_blk = PAD_PAIR;
            BLK_PAD_EMPTY: sha_blk = PAD_EMPTY;
            default:       sha_blk = blk_reg;
        endcase
    end

    mrkl_sha u_sha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sha_start),
        .init  (cmd.sha_init),
        .block (sha_blk),
        .hash  (hash),
        .done  (sha_done)
    );

    assign stat.sha_done = sha_done;
    assign root_word     = root_reg;

endmodule

[rtl/mrkl_ctrl.sv]
// controller: leaf counting, tree walk sequencing and result handshake
// depends on mrkl_pkg
module mrkl_ctrl #(
    parameter int MAX_LEAVES = 64,
    parameter int LW = $clog2(MAX_LEAVES),
    parameter int CW = $clog2(MAX_LEAVES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [1:0]        leaf_word_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        root_word_index,
    output logic              last_word,
    output logic              truncated,
    output mrkl_pkg::cmd_t    cmd,
    input  mrkl_pkg::stat_t   stat,
    output logic [LW-1:0]     leaf_addr,
    output logic [1:0]        word_sel
);
    import mrkl_pkg::*;

    localparam logic [CW-1:0] MAXC = CW'(MAX_LEAVES);

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] leaf_count_reg, leaf_count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [LW-1:0] nxt_reg, nxt_next;
    logic [2:0]    sub_reg, sub_next;
    logic [1:0]    k_reg, k_next;
    logic          ov_reg, ov_next;

    logic [CW:0]   i_plus1;
    logic [CW:0]   i_plus2;
    logic [CW-1:0] right;
    logic [CW-1:0] nxt_cnt;

    assign i_plus1 = {1'b0, i_reg} + 1'b1;
    assign i_plus2 = {1'b0, i_reg} + 2'd2;
    assign right   = (i_plus1 < {1'b0, cnt_reg}) ? i_plus1[CW-1:0] : i_reg;
    assign nxt_cnt = CW'(nxt_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_LEFT;
            leaf_count_reg <= '0;
            ovf_reg        <= 1'b0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            nxt_reg        <= '0;
            sub_reg        <= '0;
            k_reg          <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            leaf_count_reg <= leaf_count_next;
            ovf_reg        <= ovf_next;
            cnt_reg        <= cnt_next;
            i_reg          <= i_next;
            nxt_reg        <= nxt_next;
            sub_reg        <= sub_next;
            k_reg          <= k_next;
            ov_reg         <= ov_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        leaf_count_next = leaf_count_reg;
        ovf_next        = ovf_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        nxt_next        = nxt_reg;
        sub_next        = sub_reg;
        k_next          = k_reg;
        ov_next         = ov_reg;
        cmd             = '0;
        cmd.blk_sel     = BLK_DATA;
        leaf_addr       = '0;
        word_sel        = '0;
        in_stall        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                leaf_addr = leaf_count_reg[LW-1:0];
                word_sel  = leaf_word_index;
                if (in_valid)
                begin
                    if (action == ACT_LEAF)
                    begin
                        if (leaf_count_reg == MAXC)
                            ovf_next = 1'b1;
                        else
                        begin
                            cmd.wr_in = 1'b1;
                            if (leaf_word_index == 2'd3)
                                leaf_count_next = leaf_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = leaf_count_reg;
                        i_next   = '0;
                        nxt_next = '0;
                        sub_next = '0;
                        k_next   = '0;
                        if (leaf_count_reg == '0)
                        begin
                            cmd.sha_start = 1'b1;
                            cmd.sha_init  = 1'b1;
                            cmd.blk_sel   = BLK_PAD_EMPTY;
                            phase_next    = PH_EMPTY;
                            state_next    = ST_HASH;
                        end
                        else if (leaf_count_reg == CW'(1))
                            state_next = ST_OUTR;
                        else
                        begin
                            phase_next = PH_LEFT;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD:
            begin
                leaf_addr = (phase_reg == PH_LEFT) ? i_reg[LW-1:0] : right[LW-1:0];
                word_sel  = sub_reg[1:0];
                cmd.rd    = (sub_reg < 3'd4);
                if (sub_reg >= 3'd1 && sub_reg <= 3'd4)
                begin
                    cmd.cap      = 1'b1;
                    cmd.cap_slot = 2'(sub_reg - 3'd1);
                end
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd5)
                begin
                    cmd.sha_start = 1'b1;
                    cmd.sha_init  = (phase_reg == PH_LEFT);
                    sub_next      = '0;
                    state_next    = ST_HASH;
                end
            end

            ST_HASH:
            begin
                if (stat.sha_done)
                begin
                    case (phase_reg)
                        PH_LEFT:
                        begin
                            phase_next = PH_RIGHT;
                            state_next = ST_LOAD;
                        end
                        PH_RIGHT:
                        begin
                            cmd.sha_start = 1'b1;
                            cmd.blk_sel   = BLK_PAD_PAIR;
                            phase_next    = PH_PAD;
                        end
                        default:
                        begin
                            sub_next   = '0;
                            state_next = ST_WRB;
                        end
                    endcase
                end
            end

            ST_WRB:
            begin
                leaf_addr   = nxt_reg;
                word_sel    = sub_reg[1:0];
                cmd.wr_hash = 1'b1;
                sub_next    = sub_reg + 3'd1;
                if (sub_reg == 3'd3)
                begin
                    sub_next = '0;
                    if (phase_reg == PH_EMPTY)
                        state_next = ST_OUTR;
                    else if (i_plus2 >= {1'b0, cnt_reg})
                    begin
                        cnt_next = nxt_cnt;
                        i_next   = '0;
                        nxt_next = '0;
                        if (nxt_cnt == CW'(1))
                            state_next = ST_OUTR;
                        else
                        begin
                            phase_next = PH_LEFT;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        i_next     = i_plus2[CW-1:0];
                        nxt_next   = nxt_reg + 1'b1;
                        phase_next = PH_LEFT;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_OUTR:
            begin
                leaf_addr = '0;
                word_sel  = k_reg;
                cmd.rd    = (sub_reg == 3'd0);
                sub_next  = 3'd1;
                if (sub_reg != 3'd0)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    sub_next     = '0;
                    state_next   = ST_OUTW;
                end
            end

            ST_OUTW:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    k_next  = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        leaf_count_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                        state_next = ST_OUTR;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid       = ov_reg;
    assign root_word_index = k_reg;
    assign last_word       = (k_reg == 2'd3);
    assign truncated       = ovf_reg;

endmodule

[bench/testbench.sv]
// self-checking bench for merkle_root_sha256_hex: leaf words and end-of-set words in,
// roots checked against an in-bench sha-256 merkle predictor
// depends on mrkl_pkg and the rtl top level
module testbench;
    import mrkl_pkg::*;

    typedef struct {
        logic [0:0]  act;
        logic [63:0] word;
        logic [1:0]  idx;
    } leaf_item_t;

    typedef struct {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
        logic        trunc;
    } root_word_t;

    localparam int LEAF_LIMIT = 64;
    localparam int IDLE_LIMIT = 200000;

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam bit [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [63:0] leaf_word;
    logic [1:0]  leaf_word_index;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] root_word;
    logic [1:0]  root_word_index;
    logic        last_word;
    logic        truncated;

    leaf_item_t  pending_words[$];
    root_word_t  expected_roots[$];

    bit [63:0]   digest_mem[LEAF_LIMIT * 4];
    int          leaf_cnt;
    bit          ovf;

    // generator's own view of the store, to keep counted leaves fully written
    bit          gen_written[LEAF_LIMIT * 4];
    int          gen_cnt;

    int          errors;
    int          sets_done;
    int          roots_seen;
    int          trunc_roots;
    int          idle_cycles;
    int          in_gap;
    int          out_gap;
    bit          took;

    merkle_root_sha256_hex dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .leaf_word(leaf_word), .leaf_word_index(leaf_word_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .root_word(root_word), .root_word_index(root_word_index),
        .last_word(last_word), .truncated(truncated)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [31:0] ror(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic bit [255:0] sha_block(bit [255:0] hin, bit [511:0] blk);
        bit [31:0] w[64];
        bit [31:0] v[8];
        bit [31:0] t1;
        bit [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = blk[511 - 32 * t -: 32];
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int i = 0; i < 8; i++)
            v[i] = hin[255 - 32 * i -: 32];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hin[255 - 32 * i -: 32] = hin[255 - 32 * i -: 32] + v[i];
        return hin;
    endfunction

    function automatic bit [511:0] digest_text(int slot);
        bit [511:0] s;
        bit [3:0]   n;
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 16; i++)
            begin
                n = digest_mem[slot * 4 + k][63 - 4 * i -: 4];
                s[511 - 128 * k - 8 * i -: 8] = (n < 4'd10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
            end
        return s;
    endfunction

    // merkle reduction of the loaded leaves, pushes the four root words
    task automatic predict_root();
        bit [255:0]  h;
        bit [1023:0] msg;
        int          n;
        int          nxt;
        int          r;
        n = leaf_cnt;
        if (n == 0)
            h = sha_block(SHA_IV, {32'h8000_0000, 480'd0});
        else
        begin
            while (n > 1)
            begin
                nxt = 0;
                for (int i = 0; i < n; i += 2)
                begin
                    r = (i + 1 < n) ? i + 1 : i;
                    msg = {digest_text(i), digest_text(r)};
                    h = sha_block(SHA_IV, msg[1023:512]);
                    h = sha_block(h, msg[511:0]);
                    h = sha_block(h, {32'h8000_0000, 448'd0, 32'h0000_0400});
                    for (int k = 0; k < 4; k++)
                        digest_mem[nxt * 4 + k] = h[255 - 64 * k -: 64];
                    nxt++;
                end
                n = nxt;
            end
            for (int k = 0; k < 4; k++)
                h[255 - 64 * k -: 64] = digest_mem[k];
        end
        for (int k = 0; k < 4; k++)
            expected_roots.push_back('{h[255 - 64 * k -: 64], k[1:0], k == 3, ovf});
        if (ovf)
            trunc_roots++;
        leaf_cnt = 0;
        ovf = 1'b0;
        sets_done++;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    task automatic queue_word(logic [63:0] w, logic [1:0] idx);
        if (gen_cnt < LEAF_LIMIT)
        begin
            gen_written[gen_cnt * 4 + idx] = 1'b1;
            if (idx == 2'd3)
                gen_cnt++;
        end
        pending_words.push_back('{ACT_LEAF, w, idx});
    endtask

    task automatic queue_end();
        gen_cnt = 0;
        pending_words.push_back('{ACT_END, {$urandom, $urandom}, 2'($urandom_range(0, 3))});
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_leaf(logic [63:0] w);
        for (int k = 0; k < 4; k++)
            queue_word(w == '1 || w == '0 ? w : rand_word(), k[1:0]);
    endtask

    // stray word: index 3 only when the open slot is fully written or the store is full
    task automatic queue_noise();
        logic [1:0] idx;
        idx = 2'($urandom_range(0, 3));
        if (idx == 2'd3 && gen_cnt < LEAF_LIMIT &&
            !(gen_written[gen_cnt * 4] && gen_written[gen_cnt * 4 + 1] &&
              gen_written[gen_cnt * 4 + 2]))
            idx = 2'($urandom_range(0, 2));
        queue_word(rand_word(), idx);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // monitor: acceptance on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout with %0d words pending", expected_roots.size());
                $display("merkle_root_sha256_hex regression: fail");
                $finish;
            end
            idle_cycles = idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                took = 1'b1;
                idle_cycles = 0;
                if (action == ACT_LEAF)
                begin
                    if (leaf_cnt >= LEAF_LIMIT)
                        ovf = 1'b1;
                    else
                    begin
                        digest_mem[leaf_cnt * 4 + leaf_word_index] = leaf_word;
                        if (leaf_word_index == 2'd3)
                            leaf_cnt++;
                    end
                end
                else
                    predict_root();
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                roots_seen++;
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected root word", root_word, 64'd0);
                else
                begin
                    if (root_word !== expected_roots[0].word)
                        report_mismatch("root_word", root_word, expected_roots[0].word);
                    if (root_word_index !== expected_roots[0].idx)
                        report_mismatch("root_word_index", 64'(root_word_index),
                                        64'(expected_roots[0].idx));
                    if (last_word !== expected_roots[0].last)
                        report_mismatch("last_word", 64'(last_word),
                                        64'(expected_roots[0].last));
                    if (truncated !== expected_roots[0].trunc)
                        report_mismatch("truncated", 64'(truncated),
                                        64'(expected_roots[0].trunc));
                    void'(expected_roots.pop_front());
                end
            end
        end
    end

    // driver: input words and output stall, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || took)
            begin
                if (in_gap > 0 || pending_words.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    action <= pending_words[0].act;
                    leaf_word <= pending_words[0].word;
                    leaf_word_index <= pending_words[0].idx;
                    void'(pending_words.pop_front());
                    in_gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
                end
            end
            took = 1'b0;
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    out_gap = pick_gap();
            end
        end
    end

    initial
    begin
        int n_leaves;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACT_LEAF;
        leaf_word = '0;
        leaf_word_index = '0;
        errors = 0;
        sets_done = 0;
        roots_seen = 0;
        trunc_roots = 0;
        idle_cycles = 0;
        in_gap = 0;
        out_gap = 0;
        took = 1'b0;
        leaf_cnt = 0;
        ovf = 1'b0;
        gen_cnt = 0;

        // directed: empty set, single extreme leaves, odd level
        queue_end();
        queue_leaf('1);
        queue_end();
        queue_leaf('0);
        queue_end();
        for (int i = 0; i < 3; i++)
            queue_leaf(rand_word() | 64'h1);
        queue_end();

        // random sets; one full store with overflow words early on
        for (int s = 0; pending_words.size() < 520; s++)
        begin
            if (s == 2)
                n_leaves = LEAF_LIMIT + 2;
            else if ($urandom_range(0, 14) == 0)
                n_leaves = $urandom_range(7, LEAF_LIMIT);
            else
                n_leaves = $urandom_range(0, 6);
            for (int i = 0; i < n_leaves; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise();
                queue_leaf(64'h5);
            end
            if ($urandom_range(0, 6) == 0)
                for (int k = 0; k < $urandom_range(1, 3); k++)
                    queue_word(rand_word(), k[1:0]);
            queue_end();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && !in_valid && expected_roots.size() == 0);
        repeat (400) @(posedge clk);
        $display("%0d leaf sets reduced, %0d root words checked, %0d roots flagged truncated",
                 sets_done, roots_seen, trunc_roots);
        if (errors == 0)
            $display("merkle_root_sha256_hex regression: pass");
        else
            $display("merkle_root_sha256_hex regression: fail");
        $finish;
    end
endmodule
